FILE: sv/key_value_table_linear_search_macros.svh
// Assertion macros for the key/value table with linear search.
// No dependencies; included by the top level, which supplies clk and rst_n.
`ifndef KEY_VALUE_TABLE_LINEAR_SEARCH_MACROS_SVH
`define KEY_VALUE_TABLE_LINEAR_SEARCH_MACROS_SVH

// Property checked at every clock edge outside reset.
`define KVTS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent checked at the next clock after the antecedent holds.
`define KVTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/kvts_pkg.sv
// Shared types and constants of the key/value table with linear search.
// No dependencies.
package kvts_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int OP_W         = 2;
    localparam int KEY_W        = 64;
    localparam int VALUE_W      = 64;
    localparam int STATUS_W     = 3;
    localparam int SLOT_W       = 6;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam op_t OP_PUT    = 2'd0;
    localparam op_t OP_GET    = 2'd1;
    localparam op_t OP_DELETE = 2'd2;
    localparam op_t OP_NONE   = 2'd3;

    localparam status_t ST_UPDATED     = 3'd0;
    localparam status_t ST_INSERTED    = 3'd1;
    localparam status_t ST_FOUND       = 3'd2;
    localparam status_t ST_GET_MISSING = 3'd3;
    localparam status_t ST_DELETED     = 3'd4;
    localparam status_t ST_DEL_MISSING = 3'd5;
    localparam status_t ST_FULL        = 3'd6;

endpackage

FILE: sv/kvts_if.sv
// Request and response channel interfaces of the key/value table.
// Depends on kvts_pkg.
interface kvts_req_if import kvts_pkg::*;;
    logic                 valid;
    logic                 ready;
    op_t                  op;
    logic [KEY_W-1:0]     key;
    logic [VALUE_W-1:0]   value;

    modport source (output valid, output op, output key, output value, input ready);
    modport sink   (input valid, input op, input key, input value, output ready);
endinterface

interface kvts_rsp_if import kvts_pkg::*;;
    logic                 valid;
    logic                 ready;
    status_t              status;
    logic [VALUE_W-1:0]   value_out;
    logic [SLOT_W-1:0]    slot;

    modport source (output valid, output status, output value_out, output slot, input ready);
    modport sink   (input valid, input status, input value_out, input slot, output ready);
endinterface

FILE: sv/kvts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module kvts_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              write_en,
    input  logic [ADDR_W-1:0] write_addr,
    input  logic [WIDTH-1:0]  write_data,
    input  logic              read_en,
    input  logic [ADDR_W-1:0] read_addr,
    output logic [WIDTH-1:0]  read_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] read_data_reg;

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            mem_reg[write_addr] <= write_data;
        end
        if (read_en)
        begin
            read_data_reg <= mem_reg[read_addr];
        end
    end

    assign read_data = read_data_reg;

endmodule

FILE: sv/key_value_table_linear_search.sv
// Key/value table with linear search. A request (put, get or delete) is taken only while the
// block is idle and then occupies it until its response is loaded: the request is captured, the
// filled slots are scanned in order through the key RAM's registered read for the first equal
// key, and the RAMs are updated and the response register is loaded, which waits while an earlier
// response has not been taken. The scan stops early at the first match. Op code 3 is dropped in
// the capture cycle and gives no response. A put of a new key to a full table answers "full"
// and changes nothing; a delete leaves a zeroed hole and the fill count never shrinks. Entries
// are never read before they are written, so the RAMs need no clearing after reset.
// Depends on kvts_pkg, kvts_if, kvts_ram and the assertion macro header.
`include "key_value_table_linear_search_macros.svh"

module key_value_table_linear_search import kvts_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic              clk,
    input  logic              rst_n,
    kvts_req_if.sink          req,
    kvts_rsp_if.source        rsp
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_ACT  = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [CNT_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                 hit_reg, hit_next;
    logic [IDX_W-1:0]     hit_idx_reg, hit_idx_next;
    logic [VALUE_W-1:0]   hit_value_reg, hit_value_next;

    op_t                  op_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [VALUE_W-1:0]   value_reg;

    logic                 rsp_valid_reg, rsp_valid_next;
    status_t              status_reg, status_next;
    logic [VALUE_W-1:0]   value_out_reg, value_out_next;
    logic [IDX_W-1:0]     slot_idx_reg, slot_idx_next;
    logic [IDX_W+5:0]     slot_wide;

    logic                 req_fire;
    logic                 act_fire;
    logic                 cmp_hit;
    logic                 scan_more;
    logic                 table_full;

    logic                 read_en;
    logic [IDX_W-1:0]     read_addr;
    logic [KEY_W-1:0]     key_rdata;
    logic [VALUE_W-1:0]   value_rdata;
    logic                 key_we, value_we;
    logic [IDX_W-1:0]     write_addr;
    logic [KEY_W-1:0]     key_wdata;
    logic [VALUE_W-1:0]   value_wdata;

    assign req.ready  = (state_reg == S_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign act_fire   = (state_reg == S_ACT) && (!rsp_valid_reg || rsp.ready);
    assign cmp_hit    = cmp_valid_reg && (key_rdata == key_reg);
    assign scan_more  = (scan_idx_reg < fill_reg);
    assign table_full = (fill_reg == CNT_W'(CAPACITY));
    assign read_en    = (state_reg == S_SCAN) && !cmp_hit && scan_more;
    assign read_addr  = scan_idx_reg[IDX_W-1:0];

    kvts_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk        (clk),
        .write_en   (key_we),
        .write_addr (write_addr),
        .write_data (key_wdata),
        .read_en    (read_en),
        .read_addr  (read_addr),
        .read_data  (key_rdata)
    );

    kvts_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .clk        (clk),
        .write_en   (value_we),
        .write_addr (write_addr),
        .write_data (value_wdata),
        .read_en    (read_en),
        .read_addr  (read_addr),
        .read_data  (value_rdata)
    );

    // Sequencer: capture, scan, act
    always_comb
    begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_value_next = hit_value_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire && (req.op != OP_NONE))
                begin
                    state_next    = S_SCAN;
                    scan_idx_next = '0;
                end
            end
            S_SCAN:
            begin
                if (cmp_hit)
                begin
                    hit_next       = 1'b1;
                    hit_idx_next   = cmp_idx_reg;
                    hit_value_next = value_rdata;
                    state_next     = S_ACT;
                end
                else if (scan_more)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next  = scan_idx_reg + 1'b1;
                end
                else
                begin
                    hit_next   = 1'b0;
                    state_next = S_ACT;
                end
            end
            S_ACT:
            begin
                if (act_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Table update and response
    always_comb
    begin
        fill_next      = fill_reg;
        key_we         = 1'b0;
        value_we       = 1'b0;
        write_addr     = hit_idx_reg;
        key_wdata      = '0;
        value_wdata    = '0;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        status_next    = status_reg;
        value_out_next = value_out_reg;
        slot_idx_next  = slot_idx_reg;
        if (act_fire)
        begin
            rsp_valid_next = 1'b1;
            value_out_next = '0;
            slot_idx_next  = '0;
            case (op_reg)
                OP_PUT:
                begin
                    if (hit_reg)
                    begin
                        value_we       = 1'b1;
                        value_wdata    = value_reg;
                        status_next    = ST_UPDATED;
                        value_out_next = value_reg;
                        slot_idx_next  = hit_idx_reg;
                    end
                    else if (table_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        key_we         = 1'b1;
                        value_we       = 1'b1;
                        write_addr     = fill_reg[IDX_W-1:0];
                        key_wdata      = key_reg;
                        value_wdata    = value_reg;
                        fill_next      = fill_reg + 1'b1;
                        status_next    = ST_INSERTED;
                        value_out_next = value_reg;
                        slot_idx_next  = fill_reg[IDX_W-1:0];
                    end
                end
                OP_GET:
                begin
                    if (hit_reg)
                    begin
                        status_next    = ST_FOUND;
                        value_out_next = hit_value_reg;
                        slot_idx_next  = hit_idx_reg;
                    end
                    else
                    begin
                        status_next = ST_GET_MISSING;
                    end
                end
                OP_DELETE:
                begin
                    if (hit_reg)
                    begin
                        // leave a zeroed hole, count stays
                        key_we        = 1'b1;
                        value_we      = 1'b1;
                        status_next   = ST_DELETED;
                        slot_idx_next = hit_idx_reg;
                    end
                    else
                    begin
                        status_next = ST_DEL_MISSING;
                    end
                end
                default:
                begin
                    rsp_valid_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg    <= req.op;
            key_reg   <= req.key;
            value_reg <= req.value;
        end
        cmp_idx_reg   <= cmp_idx_next;
        hit_reg       <= hit_next;
        hit_idx_reg   <= hit_idx_next;
        hit_value_reg <= hit_value_next;
        status_reg    <= status_next;
        value_out_reg <= value_out_next;
        slot_idx_reg  <= slot_idx_next;
    end

    assign slot_wide     = {6'b0, slot_idx_reg};
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.value_out = value_out_reg;
    assign rsp.slot      = slot_wide[SLOT_W-1:0];

    `KVTS_ASSERT_ALWAYS(a_fill_bound, fill_reg <= CNT_W'(CAPACITY), "fill count above capacity")
    `KVTS_ASSERT_ALWAYS(a_scan_bound, scan_idx_reg <= fill_reg, "scan ran past filled slots")
    `KVTS_ASSERT_NEXT(a_scan_to_act, state_reg == S_SCAN, state_reg != S_IDLE,
        "scan returned to idle without acting")
    `KVTS_ASSERT_NEXT(a_insert_count, act_fire && key_we && (op_reg == OP_PUT),
        fill_reg == $past(fill_reg) + 1'b1, "insert did not advance the fill count")

endmodule
